// File: design/fixed_block_pool_allocator_unit_macros.svh
// Assertion macros used by the allocator sequencer (fbpa_ctrl).
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted. Expects clk_i and rst_ni in scope.
`define FBPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define FBPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/fbpa_pkg.sv
// Shared constants, types and helper functions of the block pool allocator.
package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned ADDR_WIDTH = 32;

  // Link values run 0..MAX_BLOCKS, MAX_BLOCKS being the null link.
  localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned MEM_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned K_W    = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  localparam int unsigned BASE_W    = 32;
  localparam int unsigned BSIZE_W   = 17;
  localparam int unsigned BCOUNT_W  = 9;
  localparam int unsigned PALIGN_W  = 13;
  localparam int unsigned TYPE_W    = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned ADDRF_W   = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Effective block size: block size up to 2^17-1 rounded up to a multiple of the effective alignment (at most 4096).
  localparam int unsigned ESIZE_W = BSIZE_W + 1;
  localparam int unsigned SPAN_W  = ESIZE_W + IDX_W;

  localparam logic [IDX_W-1:0] NULL_LINK = IDX_W'(MAX_BLOCKS);

  localparam logic [BASE_W-1:0]   RST_BASE   = BASE_W'(0);
  localparam logic [BSIZE_W-1:0]  RST_BSIZE  = BSIZE_W'(64);
  localparam logic [BCOUNT_W-1:0] RST_BCOUNT = BCOUNT_W'(256);
  localparam logic [PALIGN_W-1:0] RST_PALIGN = PALIGN_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS   = 2'd0,
    CFG_BLK_BYTES      = 2'd1,
    CFG_BLK_NUM        = 2'd2,
    CFG_POOL_ALIGNMENT = 2'd3
  } cfg_idx_e;

  typedef enum logic [TYPE_W-1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_RESET = 2'd2
  } req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_SIZE_BIG  = 3'd2,
    ST_ALIGN_BIG = 3'd3,
    ST_RANGE     = 3'd4,
    ST_MISALIGN  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_DIVIDE,
    S_FREE_END,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [BASE_W-1:0]   base_address;
    logic [BSIZE_W-1:0]  blk_bytes;
    logic [BCOUNT_W-1:0] blk_num;
    logic [PALIGN_W-1:0] pool_alignment;
  } cfg_t;

  typedef struct packed {
    logic load;       // latch request word and effective geometry
    logic calc;       // products, offset, link read
    logic fin_alloc;  // alloc outcome, pop on success
    logic fin_range;  // free rejected by range check
    logic div_start;
    logic div_step;
    logic fin_free;   // free outcome, push on success
    logic fin_build;  // rebuild the free list
    logic fin_nop;    // unknown request type
    logic out_load;   // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              range_err;
    logic              div_last;
  } dp_sts_t;

  // Largest power of two not above the register; zero acts as one.
  function automatic logic [PALIGN_W-1:0] eff_align(input logic [PALIGN_W-1:0] pa);
    logic [PALIGN_W-1:0] r;
    r = PALIGN_W'(1);
    for (int i = 0; i < PALIGN_W; i++) begin
      if (pa[i]) r = PALIGN_W'(1) << i;
    end
    return r;
  endfunction

  function automatic logic [ESIZE_W-1:0] eff_size(input logic [BSIZE_W-1:0]  bsize,
                                                  input logic [PALIGN_W-1:0] ealign);
    logic [ESIZE_W-1:0] bs;
    logic [ESIZE_W-1:0] am1;
    bs  = (bsize == '0) ? ESIZE_W'(1) : ESIZE_W'(bsize);
    am1 = ESIZE_W'(ealign) - ESIZE_W'(1);
    return (bs + am1) & ~am1;
  endfunction

  function automatic logic [IDX_W-1:0] eff_count(input logic [BCOUNT_W-1:0] cnt);
    logic [IDX_W-1:0] r;
    if (cnt == '0) begin
      r = IDX_W'(1);
    end else if (32'(cnt) > MAX_BLOCKS) begin
      r = NULL_LINK;
    end else begin
      r = IDX_W'(cnt);
    end
    return r;
  endfunction

endpackage

// File: design/fbpa_req_if.sv
// Request channel: valid/ready handshake with the request word.
interface fbpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [fbpa_pkg::TYPE_W-1:0]  req_type;
  logic [fbpa_pkg::BSIZE_W-1:0] req_size;
  logic [fbpa_pkg::PALIGN_W-1:0] req_alignment;
  logic [fbpa_pkg::ADDRF_W-1:0] req_address;

  modport source (output valid, req_type, req_size, req_alignment, req_address,
                  input ready);
  modport sink   (input valid, req_type, req_size, req_alignment, req_address,
                  output ready);
endinterface

// File: design/fbpa_rsp_if.sv
// Response channel: valid/ready handshake with the result word.
interface fbpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fbpa_pkg::STATUS_W-1:0] status;
  logic [fbpa_pkg::ADDRF_W-1:0]  block_address;

  modport source (output valid, status, block_address, input ready);
  modport sink   (input valid, status, block_address, output ready);
endinterface

// File: design/fixed_block_pool_allocator_unit.sv
// Top level of the fixed-size block pool allocator with a LIFO free list.
//
//  channel   dir   word                                               handshake
//  req       in    req_type, req_size, req_alignment, req_address     valid/ready
//  rsp       out   status, block_address                              valid/ready
//  cfg       in    cfg_idx_i, cfg_wdata_i                             cfg_we_i, no wait
//
// One word at a time. Alloc, pool reset, unknown types and out-of-range frees step
// through calc, decide and done after the accept; an in-range free also runs the
// restoring divider (one quotient bit per cycle) and a free-end step before done.
// Pool reset and hardware reset rebuild the list by clearing the link valid bits;
// there is no clearing pass.
// A waiting result does not block the next accept; a second finished result stalls.
module fixed_block_pool_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fbpa_req_if.sink                       req,
  fbpa_rsp_if.source                     rsp,
  input  logic                           cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fbpa_pkg::CFG_W-1:0]     cfg_wdata_i
);

  fbpa_pkg::cfg_t    cfg_q;
  fbpa_pkg::dp_cmd_t cmd;
  fbpa_pkg::dp_sts_t sts;
  logic              req_ready;
  logic              rsp_valid;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_address   <= fbpa_pkg::RST_BASE;
      cfg_q.blk_bytes      <= fbpa_pkg::RST_BSIZE;
      cfg_q.blk_num        <= fbpa_pkg::RST_BCOUNT;
      cfg_q.pool_alignment <= fbpa_pkg::RST_PALIGN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fbpa_pkg::CFG_BASE_ADDRESS:
          cfg_q.base_address <= cfg_wdata_i[fbpa_pkg::BASE_W-1:0];
        fbpa_pkg::CFG_BLK_BYTES:
          cfg_q.blk_bytes <= cfg_wdata_i[fbpa_pkg::BSIZE_W-1:0];
        fbpa_pkg::CFG_BLK_NUM:
          cfg_q.blk_num <= cfg_wdata_i[fbpa_pkg::BCOUNT_W-1:0];
        fbpa_pkg::CFG_POOL_ALIGNMENT:
          cfg_q.pool_alignment <= cfg_wdata_i[fbpa_pkg::PALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: accepts a word in idle, then steps the datapath.
  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req_ready),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: geometry, link memory, divider, result and output registers.
  fbpa_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .req_type_i      (req.req_type),
    .req_size_i      (req.req_size),
    .req_alignment_i (req.req_alignment),
    .req_address_i   (req.req_address),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (rsp.status),
    .block_address_o (rsp.block_address)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

endmodule

// File: design/fbpa_ctrl.sv
// Sequencer of the allocator: walks each request through the datapath.
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  fbpa_pkg::dp_sts_t sts_i,
  output fbpa_pkg::dp_cmd_t cmd_o
);

  fbpa_pkg::state_e state_q, state_d;
  logic             rsp_valid_q, rsp_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbpa_pkg::S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      fbpa_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fbpa_pkg::S_CALC;
        end
      end
      fbpa_pkg::S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = fbpa_pkg::S_DECIDE;
      end
      fbpa_pkg::S_DECIDE: begin
        state_d = fbpa_pkg::S_DONE;
        unique case (sts_i.req_type)
          fbpa_pkg::REQ_ALLOC: cmd_o.fin_alloc = 1'b1;
          fbpa_pkg::REQ_FREE: begin
            if (sts_i.range_err) begin
              cmd_o.fin_range = 1'b1;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = fbpa_pkg::S_DIVIDE;
            end
          end
          fbpa_pkg::REQ_RESET: cmd_o.fin_build = 1'b1;
          default:             cmd_o.fin_nop   = 1'b1;
        endcase
      end
      fbpa_pkg::S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = fbpa_pkg::S_FREE_END;
      end
      fbpa_pkg::S_FREE_END: begin
        cmd_o.fin_free = 1'b1;
        state_d        = fbpa_pkg::S_DONE;
      end
      fbpa_pkg::S_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = fbpa_pkg::S_IDLE;
        end
      end
      default: state_d = fbpa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_ready_i) rsp_valid_d = 1'b0;
    if (cmd_o.out_load)             rsp_valid_d = 1'b1;
  end

  assign rsp_valid_o = rsp_valid_q;

  `FBPA_ASSERT(a_accept_to_calc, (req_valid_i && req_ready_o) |=> (state_q == fbpa_pkg::S_CALC), "accepted word did not start the sequence")
  `FBPA_ASSERT(a_no_overwrite, cmd_o.out_load |-> (!rsp_valid_q || rsp_ready_i), "pending result overwritten")
  `FBPA_ASSERT(a_divide_holds, (state_q == fbpa_pkg::S_DIVIDE && !sts_i.div_last) |=> (state_q == fbpa_pkg::S_DIVIDE), "division left early")
  `FBPA_ASSERT(a_free_end_type, (state_q == fbpa_pkg::S_FREE_END) |-> (sts_i.req_type == fbpa_pkg::REQ_FREE), "free completion on a non-free request")

endmodule

// File: design/fbpa_dpath.sv
// Datapath of the allocator: geometry, link memory, divider and result registers.
module fbpa_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbpa_pkg::cfg_t                cfg_i,
  input  logic [fbpa_pkg::TYPE_W-1:0]   req_type_i,
  input  logic [fbpa_pkg::BSIZE_W-1:0]  req_size_i,
  input  logic [fbpa_pkg::PALIGN_W-1:0] req_alignment_i,
  input  logic [fbpa_pkg::ADDRF_W-1:0]  req_address_i,
  input  fbpa_pkg::dp_cmd_t             cmd_i,
  output fbpa_pkg::dp_sts_t             sts_o,
  output logic [fbpa_pkg::STATUS_W-1:0] status_o,
  output logic [fbpa_pkg::ADDRF_W-1:0]  block_address_o
);

  localparam int unsigned IW  = fbpa_pkg::IDX_W;
  localparam int unsigned AW  = fbpa_pkg::MEM_AW;
  localparam int unsigned SW  = fbpa_pkg::SPAN_W;
  localparam int unsigned EW  = fbpa_pkg::ESIZE_W;
  localparam int unsigned KW  = fbpa_pkg::K_W;
  localparam int unsigned XW  = fbpa_pkg::ADDR_WIDTH;

  // request word and effective geometry
  logic [fbpa_pkg::TYPE_W-1:0]   type_q;
  logic [fbpa_pkg::BSIZE_W-1:0]  size_q;
  logic [fbpa_pkg::PALIGN_W-1:0] align_q;
  logic [fbpa_pkg::ADDRF_W-1:0]  addr_q;
  logic [fbpa_pkg::PALIGN_W-1:0] ealign_q;
  logic [EW-1:0]                 esize_q;
  logic [IW-1:0]                 ecount_q;

  // first-stage results
  logic [SW-1:0]                 span_q;
  logic [SW-1:0]                 prod_q;
  logic [fbpa_pkg::ADDRF_W-1:0]  offs_q;
  logic                          below_q;

  // divider
  logic [SW-1:0] rem_q;
  logic [IW-1:0] quo_q;
  logic [KW-1:0] k_q;

  // link memory with per-entry valid bits; unwritten entries read as the rebuilt list
  logic [IW-1:0]         mem_q [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::MAX_BLOCKS-1:0] valid_q;
  logic [IW-1:0]         build_n_q;
  logic [IW-1:0]         head_q;
  logic [IW-1:0]         rd_data_q;
  logic [AW-1:0]         rd_addr_q;
  logic                  rd_valid_q;

  logic [fbpa_pkg::STATUS_W-1:0] res_status_q;
  logic [fbpa_pkg::ADDRF_W-1:0]  res_addr_q;

  logic [fbpa_pkg::PALIGN_W-1:0] ealign_c;
  logic [IW-1:0]                 link_dflt;
  logic [IW-1:0]                 link;
  logic [SW-1:0]                 dvsr;
  logic                          ge;
  logic [XW-1:0]                 alloc_sum;
  fbpa_pkg::status_e             alloc_st;
  logic                          push_ok;

  assign ealign_c = fbpa_pkg::eff_align(cfg_i.pool_alignment);

  assign link_dflt = ((IW'(rd_addr_q) + IW'(1)) < build_n_q) ? (IW'(rd_addr_q) + IW'(1))
                                                              : fbpa_pkg::NULL_LINK;
  assign link      = rd_valid_q ? rd_data_q : link_dflt;

  assign dvsr = SW'(esize_q) << k_q;
  assign ge   = (rem_q >= dvsr);

  assign alloc_sum = XW'(cfg_i.base_address) + XW'(prod_q);

  always_comb begin
    priority if ({1'b0, size_q} > esize_q) begin
      alloc_st = fbpa_pkg::ST_SIZE_BIG;
    end else if (align_q > ealign_q) begin
      alloc_st = fbpa_pkg::ST_ALIGN_BIG;
    end else if (head_q >= fbpa_pkg::NULL_LINK) begin
      alloc_st = fbpa_pkg::ST_EMPTY;
    end else begin
      alloc_st = fbpa_pkg::ST_OK;
    end
  end

  assign push_ok = (rem_q == '0) && (32'(quo_q) < fbpa_pkg::MAX_BLOCKS);

  assign sts_o.req_type  = type_q;
  assign sts_o.range_err = below_q || (offs_q >= fbpa_pkg::ADDRF_W'(span_q));
  assign sts_o.div_last  = (k_q == '0);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q   <= req_type_i;
      size_q   <= req_size_i;
      align_q  <= req_alignment_i;
      addr_q   <= req_address_i;
      ealign_q <= ealign_c;
      esize_q  <= fbpa_pkg::eff_size(cfg_i.blk_bytes, ealign_c);
      ecount_q <= fbpa_pkg::eff_count(cfg_i.blk_num);
    end
    if (cmd_i.calc) begin
      span_q     <= SW'(esize_q) * SW'(ecount_q);
      prod_q     <= SW'(esize_q) * SW'(head_q);
      offs_q     <= addr_q - cfg_i.base_address;
      below_q    <= (addr_q < cfg_i.base_address);
      rd_data_q  <= mem_q[head_q[AW-1:0]];
      rd_valid_q <= valid_q[head_q[AW-1:0]];
      rd_addr_q  <= head_q[AW-1:0];
    end
    if (cmd_i.div_start) begin
      rem_q <= offs_q[SW-1:0];
      quo_q <= '0;
      k_q   <= KW'(IW - 1);
    end else if (cmd_i.div_step) begin
      if (ge) rem_q <= rem_q - dvsr;
      quo_q <= IW'({quo_q, ge});
      k_q   <= k_q - KW'(1);
    end
    if (cmd_i.fin_free && push_ok) begin
      mem_q[quo_q[AW-1:0]] <= head_q;
    end
    if (cmd_i.fin_alloc) begin
      res_status_q <= alloc_st;
      res_addr_q   <= (alloc_st == fbpa_pkg::ST_OK) ? fbpa_pkg::ADDRF_W'(alloc_sum) : '0;
    end else if (cmd_i.fin_range) begin
      res_status_q <= fbpa_pkg::ST_RANGE;
      res_addr_q   <= '0;
    end else if (cmd_i.fin_free) begin
      res_status_q <= (rem_q == '0) ? fbpa_pkg::ST_OK : fbpa_pkg::ST_MISALIGN;
      res_addr_q   <= '0;
    end else if (cmd_i.fin_build || cmd_i.fin_nop) begin
      res_status_q <= fbpa_pkg::ST_OK;
      res_addr_q   <= '0;
    end
    if (cmd_i.out_load) begin
      status_o        <= res_status_q;
      block_address_o <= res_addr_q;
    end
  end

  // list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      valid_q   <= '0;
      build_n_q <= fbpa_pkg::eff_count(fbpa_pkg::RST_BCOUNT);
    end else begin
      if (cmd_i.fin_alloc && alloc_st == fbpa_pkg::ST_OK) begin
        head_q <= link;
      end else if (cmd_i.fin_free && push_ok) begin
        head_q                 <= quo_q;
        valid_q[quo_q[AW-1:0]] <= 1'b1;
      end else if (cmd_i.fin_build) begin
        head_q    <= '0;
        valid_q   <= '0;
        build_n_q <= ecount_q;
      end
    end
  end

endmodule

// File: tb/tb_fixed_block_pool_allocator_unit.sv
// Self-checking bench for the block pool allocator: free-list mirror, random traffic, stalls.
module tb_fixed_block_pool_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  // Request type with no meaning in the package; the block must answer ok / zero.
  localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 135;
  // Slowest op is an in-range free, which runs the divider. Pad beyond it before touching registers.
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    logic [TYPE_W-1:0]   kind;
    logic [BSIZE_W-1:0]  size;
    logic [PALIGN_W-1:0] align;
    logic [ADDRF_W-1:0]  addr;
  } pool_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ADDRF_W-1:0]  addr;
  } pool_reply_t;

  // Mirror of the free list and the register file. Every accepted request word is
  // applied here at once and leaves one expected reply word in due_replies.
  class block_pool_mirror;
    logic [BASE_W-1:0]   base_addr;
    logic [BSIZE_W-1:0]  blk_size;
    logic [BCOUNT_W-1:0] blk_count;
    logic [PALIGN_W-1:0] pool_align;
    int unsigned         head;
    int unsigned         link [MAX_BLOCKS];
    pool_reply_t         due_replies [$];
    logic [ADDRF_W-1:0]  held [$];      // addresses handed out, candidates for frees
    int                  errors;

    function new();
      base_addr  = RST_BASE;
      blk_size   = RST_BSIZE;
      blk_count  = RST_BCOUNT;
      pool_align = RST_PALIGN;
      errors     = 0;
      rebuild();
    endfunction

    // Alignment in force: largest power of two not above the register, at least one.
    function longint unsigned grain();
      longint unsigned g = 1;
      while ((g << 1) <= pool_align) g <<= 1;
      return g;
    endfunction

    function longint unsigned stride();
      longint unsigned bs = (blk_size == 0) ? 1 : blk_size;
      longint unsigned g  = grain();
      return ((bs + g - 1) / g) * g;
    endfunction

    function int unsigned slots();
      if (blk_count == 0) return 1;
      if (blk_count > MAX_BLOCKS) return MAX_BLOCKS;
      return blk_count;
    endfunction

    function void rebuild();
      int unsigned n = slots();
      for (int unsigned i = 0; i < MAX_BLOCKS; i++) begin
        link[i] = (i + 1 < n) ? i + 1 : MAX_BLOCKS;
      end
      head = 0;
      held.delete();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_BASE_ADDRESS:   base_addr  = val[BASE_W-1:0];
        CFG_BLK_BYTES:      blk_size   = val[BSIZE_W-1:0];
        CFG_BLK_NUM:        blk_count  = val[BCOUNT_W-1:0];
        CFG_POOL_ALIGNMENT: pool_align = val[PALIGN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return due_replies.size();
    endfunction

    function void apply_request(pool_req_t r);
      pool_reply_t     e;
      longint unsigned esz;
      longint unsigned off;
      esz      = stride();
      e.status = ST_OK;
      e.addr   = '0;
      case (r.kind)
        REQ_ALLOC: begin
          // size first, then alignment, then an empty list
          if (r.size > esz) begin
            e.status = ST_SIZE_BIG;
          end else if (r.align > grain()) begin
            e.status = ST_ALIGN_BIG;
          end else if (head >= MAX_BLOCKS) begin
            e.status = ST_EMPTY;
          end else begin
            e.addr = ADDRF_W'(64'(base_addr) + 64'(head) * esz);
            held.push_back(e.addr);
            head = link[head];
          end
        end
        REQ_FREE: begin
          // no wrap: the pool ends where base + span would overflow
          if (r.addr < base_addr ||
              (64'(r.addr) - 64'(base_addr)) >= esz * slots()) begin
            e.status = ST_RANGE;
          end else begin
            off = 64'(r.addr) - 64'(base_addr);
            if (off % esz != 0) begin
              e.status = ST_MISALIGN;
            end else begin
              link[off / esz] = head;
              head = int'(off / esz);
            end
          end
        end
        REQ_RESET: rebuild();
        default: ;
      endcase
      due_replies.push_back(e);
    endfunction

    task flag(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endtask

    task match_reply(pool_reply_t got);
      pool_reply_t e;
      if (due_replies.size() == 0) begin
        flag($sformatf("reply word with nothing outstanding: status %0d addr %08h",
                       got.status, got.addr));
        return;
      end
      e = due_replies.pop_front();
      if (got.status !== e.status)
        flag($sformatf("status got %0d want %0d", got.status, e.status));
      if (got.addr !== e.addr)
        flag($sformatf("block_address got %08h want %08h", got.addr, e.addr));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  fixed_block_pool_allocator_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  block_pool_mirror mirror = new();

  // Percent of cycles each side holds off; changed per phase.
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 71;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog, far above the slowest legal run (~1100 words, worst stalls).
  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Reply side: ready is redrawn every falling edge; words are taken at the rising edge.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready)
        mirror.match_reply('{status: rsp_ch.status, addr: rsp_ch.block_address});
    end
  end

  function automatic pool_req_t word_of(logic [TYPE_W-1:0] kind, logic [BSIZE_W-1:0] size,
                                        logic [PALIGN_W-1:0] align, logic [ADDRF_W-1:0] addr);
    pool_req_t r;
    r.kind  = kind;
    r.size  = size;
    r.align = align;
    r.addr  = addr;
    return r;
  endfunction

  // Entered and left at a falling edge. valid stays high after the accept so that
  // back-to-back words never see a low/high pair of assignments in one step.
  task automatic send_request(pool_req_t r);
    bit lowered = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      if (!lowered) begin
        req_ch.valid <= 1'b0;
        lowered = 1'b1;
      end
      @(negedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= r.kind;
    req_ch.req_size      <= r.size;
    req_ch.req_alignment <= r.align;
    req_ch.req_address   <= r.addr;
    do @(posedge clk_i); while (!req_ch.ready);
    mirror.apply_request(r);
    @(negedge clk_i);
  endtask

  // Hold the request side until every reply has come back, then pad.
  task automatic wait_quiet(int unsigned pad);
    req_ch.valid <= 1'b0;
    do @(negedge clk_i); while (mirror.outstanding() != 0);
    repeat (pad) @(negedge clk_i);
  endtask

  // Leaves cfg_we_i high; the caller drops it after the last write of a group.
  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    mirror.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Mostly legal traffic for the current geometry: fitting allocs and frees of
  // blocks handed out earlier, with some resets and a tail of junk words.
  function automatic pool_req_t random_request();
    pool_req_t       r;
    longint unsigned esz;
    longint unsigned span;
    int unsigned     sh;
    int unsigned     pick;
    int unsigned     slot;
    r.kind  = REQ_ALLOC;
    r.size  = BSIZE_W'($urandom);
    r.align = PALIGN_W'($urandom);
    r.addr  = $urandom;
    esz  = mirror.stride();
    span = esz * mirror.slots();
    sh   = 0;
    while ((64'd1 << (sh + 1)) <= mirror.grain()) sh++;
    pick = $urandom_range(99);
    if (pick >= 50 && pick < 78 && mirror.held.size() == 0) pick = 0;
    if (pick < 50) begin
      r.size  = BSIZE_W'($urandom_range(0, (esz > 131071) ? 131071 : int'(esz)));
      r.align = ($urandom_range(9) == 0) ? '0 : PALIGN_W'(1 << $urandom_range(0, sh));
    end else if (pick < 78) begin
      slot   = $urandom_range(0, mirror.held.size() - 1);
      r.kind = REQ_FREE;
      r.addr = mirror.held[slot];
      mirror.held.delete(slot);
    end else if (pick < 82) begin
      r.kind = REQ_RESET;
    end else if (pick < 89) begin
      // around the pool: just below base, inside off-boundary, just past the end
      r.kind = REQ_FREE;
      r.addr = mirror.base_addr + ADDRF_W'($urandom_range(0, int'(span) + 16)) - 32'd8;
    end else if (pick < 95) begin
      r.kind = REQ_ALLOC;   // unconstrained size and alignment
    end else if (pick < 98) begin
      r.kind = REQ_FREE;    // unconstrained address
    end else begin
      r.kind = REQ_UNKNOWN;
    end
    return r;
  endfunction

  task automatic set_idling(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 33; recv_idle_pct = 71; end
      1: begin send_idle_pct = 71; recv_idle_pct = 33; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  // Directed words: field extremes, every status, both range edges, unknown type.
  task automatic run_directed();
    // default geometry: base 0, 64-byte blocks, 256 blocks, alignment 8
    send_request(word_of(REQ_ALLOC, 17'd0, 13'd1, 32'hFFFF_FFFF));
    send_request(word_of(REQ_ALLOC, 17'd64, 13'd8, 32'd0));
    send_request(word_of(REQ_ALLOC, 17'd65, 13'd1, 32'd0));
    // size is checked ahead of alignment
    send_request(word_of(REQ_ALLOC, 17'h1FFFF, 13'h1FFF, 32'd0));
    send_request(word_of(REQ_ALLOC, 17'd1, 13'd16, 32'd0));
    send_request(word_of(REQ_ALLOC, 17'd1, 13'd0, 32'd0));
    send_request(word_of(REQ_FREE, 17'h1FFFF, 13'h1FFF, 32'd64));
    send_request(word_of(REQ_FREE, 17'd0, 13'd0, 32'h0000_4000));
    send_request(word_of(REQ_FREE, 17'd0, 13'd0, 32'hFFFF_FFFF));
    send_request(word_of(REQ_FREE, 17'd0, 13'd0, 32'd33));
    send_request(word_of(REQ_FREE, 17'd0, 13'd0, 32'h0000_3FC0));
    send_request(word_of(REQ_UNKNOWN, 17'h1FFFF, 13'h1FFF, 32'hFFFF_FFFF));
    send_request(word_of(REQ_RESET, 17'd0, 13'd0, 32'd0));
    send_request(word_of(REQ_ALLOC, 17'd8, 13'd8, 32'd0));

    // two-block pool at 0x100: drain it, then probe both range edges
    wait_quiet(SETTLE_CYCLES);
    write_reg(CFG_BLK_NUM, 32'd2);
    write_reg(CFG_BASE_ADDRESS, 32'h0000_0100);
    cfg_we_i <= 1'b0;
    send_request(word_of(REQ_RESET, 17'd0, 13'd0, 32'd0));
    send_request(word_of(REQ_ALLOC, 17'd1, 13'd1, 32'd0));
    send_request(word_of(REQ_ALLOC, 17'd1, 13'd1, 32'd0));
    send_request(word_of(REQ_ALLOC, 17'd1, 13'd1, 32'd0));   // list empty
    send_request(word_of(REQ_FREE, 17'd0, 13'd0, 32'h0000_00FF));
    send_request(word_of(REQ_FREE, 17'd0, 13'd0, 32'h0000_0180));
    send_request(word_of(REQ_FREE, 17'd0, 13'd0, 32'h0000_0140));
    send_request(word_of(REQ_ALLOC, 17'd1, 13'd1, 32'd0));
  endtask

  // One register setting, then random traffic. Phase 3 changes the geometry
  // without a pool reset, so the stale list keeps being popped.
  task automatic run_phase(int unsigned p);
    logic [BASE_W-1:0]   b;
    logic [BSIZE_W-1:0]  s;
    logic [BCOUNT_W-1:0] c;
    logic [PALIGN_W-1:0] a;
    b = $urandom;
    s = BSIZE_W'($urandom_range(1, 300));
    c = BCOUNT_W'($urandom_range(1, 40));
    a = ($urandom_range(1) == 0) ? PALIGN_W'(1 << $urandom_range(0, 6)) : PALIGN_W'($urandom);
    case (p)
      0: begin b = 32'hFFFF_FFFE; s = 17'd1; c = 9'd4; a = 13'd1; end   // addresses wrap
      1: begin b = '0; s = '0; c = '0; a = '0; end                      // zeros act as one
      2: begin s = 17'h1FFFF; c = 9'h1FF; a = 13'h1FFF; end             // all clamps at top
      3: begin b = 32'h0000_1000; s = 17'd100; c = 9'd16; a = 13'd48; end
      7: begin s = 17'd64; c = 9'd256; a = 13'd8; end
      default: ;
    endcase
    set_idling((p < 3) ? 0 : (p < 6) ? 1 : 2);
    wait_quiet(SETTLE_CYCLES);
    write_reg(CFG_BASE_ADDRESS, b);
    write_reg(CFG_BLK_BYTES, CFG_W'(s));
    write_reg(CFG_BLK_NUM, CFG_W'(c));
    write_reg(CFG_POOL_ALIGNMENT, CFG_W'(a));
    cfg_we_i <= 1'b0;
    if (p != 3) send_request(word_of(REQ_RESET, BSIZE_W'($urandom), PALIGN_W'($urandom),
                                     $urandom));
    for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
      // now and then let every reply come home before the next word
      if ($urandom_range(49) == 0) wait_quiet(0);
      send_request(random_request());
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_wdata_i          = '0;
    req_ch.valid         = 1'b0;
    req_ch.req_type      = '0;
    req_ch.req_size      = '0;
    req_ch.req_alignment = '0;
    req_ch.req_address   = '0;
    set_idling(0);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    for (int unsigned p = 0; p < PHASES; p++) run_phase(p);

    // drain, then give a stray extra reply time to show up
    req_ch.valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mirror.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
